// File: rtl/assert_macros.svh
// Assertion macros shared by the checker files of this block.
// Depends on nothing; each macro expects i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/rtd_pkg.sv
// Shared types and constants of the task dispatcher.
// Used by the controller, the datapath and the top level.
package rtd_pkg;

    localparam int NUM_TASKS   = 16;
    localparam int QUEUE_DEPTH = 16;
    localparam int ID_W        = 4;
    localparam int QP_W        = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = QP_W + 1;
    localparam int RES_MAX     = 4;

    localparam logic [1:0] OP_SUBMIT   = 2'd0;
    localparam logic [1:0] OP_NOTIFY   = 2'd1;
    localparam logic [1:0] OP_RSP_DONE = 2'd2;
    localparam logic [1:0] OP_RDP_DONE = 2'd3;

    localparam logic [1:0] KIND_GFX   = 2'd0;
    localparam logic [1:0] KIND_AUDIO = 2'd1;
    localparam logic [1:0] KIND_NULL  = 2'd2;

    localparam logic [2:0] ACT_START = 3'd0;
    localparam logic [2:0] ACT_DONE  = 3'd1;
    localparam logic [2:0] ACT_YIELD = 3'd2;
    localparam logic [2:0] ACT_SWAP  = 3'd3;
    localparam logic [2:0] ACT_ERROR = 3'd4;

    // One task table entry: attributes and running state bits.
    typedef struct packed {
        logic [1:0] kind;
        logic       nrsp;
        logic       nrdp;
        logic       swap;
        logic       has_fb;
        logic       yielded;
        logic       yld;
        logic       sp;
        logic       dp;
    } t_task;

    // One buffered result.
    typedef struct packed {
        logic [2:0]      action;
        logic [ID_W-1:0] id;
        logic            rdp;
    } t_res;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic exec;
        logic dsel;
        logic dapp;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic emit_last;
    } t_stat;

endpackage

// File: rtl/rtd_ctrl.sv
// Controller state machine of the task dispatcher.
// Depends on rtd_pkg for the command and status types.
module rtd_ctrl import rtd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DSEL,
        S_DAPP,
        S_EMIT
    } t_state;

    t_state r_state;

    // State register: one event walks through execute, dispatch and emit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: if (start) r_state <= S_EXEC;
                S_EXEC: r_state <= S_DSEL;
                S_DSEL: r_state <= S_DAPP;
                S_DAPP: r_state <= S_EMIT;
                S_EMIT: if (i_stat.emit_last) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Command decode.
    always_comb begin
        o_cmd       = '0;
        o_cmd.latch = (r_state == S_IDLE) && start;
        o_cmd.exec  = (r_state == S_EXEC);
        o_cmd.dsel  = (r_state == S_DSEL);
        o_cmd.dapp  = (r_state == S_DAPP);
        o_cmd.emit  = (r_state == S_EMIT);
    end

    assign busy = (r_state != S_IDLE);

endmodule

// File: rtl/rtd_dpath.sv
// Datapath of the task dispatcher: task table, queues, unit state, results.
// Depends on rtd_pkg; driven by commands from rtd_ctrl.
module rtd_dpath import rtd_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cmd            i_cmd,
    output t_stat           o_stat,
    input  logic [1:0]      i_operation,
    input  logic [3:0]      i_task_id,
    input  logic [1:0]      i_task_kind,
    input  logic            i_needs_rsp,
    input  logic            i_needs_rdp,
    input  logic            i_swap_buffer,
    input  logic            i_has_framebuffer,
    input  logic            i_framebuffer_ok,
    input  logic            i_rsp_yielded,
    output logic            o_valid,
    output logic [2:0]      o_action,
    output logic [3:0]      o_task_id_res,
    output logic            o_with_rdp,
    output logic            o_last
);

    // Latched event fields.
    logic [1:0]      r_op;
    logic [ID_W-1:0] r_tid;
    logic [1:0]      r_kind;
    logic            r_nrsp, r_nrdp, r_swap, r_hasfb, r_fbok, r_ryld;

    // Stores and unit state.
    t_task           r_tbl [NUM_TASKS];
    logic [ID_W-1:0] r_afifo [QUEUE_DEPTH];
    logic [ID_W-1:0] r_gdq [QUEUE_DEPTH];
    logic [QP_W-1:0] r_ahead, n_ahead, r_ghead, n_ghead;
    logic [CNT_W-1:0] r_acnt, n_acnt, r_gcnt, n_gcnt;
    logic            r_rsp_v, n_rsp_v, r_rdp_v, n_rdp_v;
    logic [ID_W-1:0] r_rsp_id, n_rsp_id, r_rdp_id, n_rdp_id;
    logic            r_disp, n_disp, r_pick, n_pick, r_both, n_both;
    logic [ID_W-1:0] r_pid, n_pid;

    // Result buffer and emit pointer.
    t_res            r_rb [RES_MAX];
    logic [2:0]      r_rcnt;
    logic [1:0]      r_eidx;

    // Write ports of the stores.
    logic            tbl_we, aq_we, gq_we;
    logic [ID_W-1:0] tbl_wa, aq_wd, gq_wd;
    logic [QP_W-1:0] aq_wa, gq_wa;
    t_task           tbl_wd;

    // Results raised this cycle, at most two.
    t_res            em [2];
    logic [1:0]      em_n;

    logic [ID_W-1:0] rd_addr;
    t_task           ent, upd;
    logic            full_q, sp_free, dp_free;
    logic [ID_W-1:0] hid;

    assign hid = r_gdq[r_ghead];

    // Table read address follows the step in progress.
    always_comb begin
        if (i_cmd.dsel) begin
            rd_addr = hid;
        end else if (i_cmd.dapp) begin
            rd_addr = r_pid;
        end else if (r_op == OP_SUBMIT) begin
            rd_addr = r_tid;
        end else if (r_op == OP_RDP_DONE) begin
            rd_addr = r_rdp_id;
        end else begin
            rd_addr = r_rsp_id;
        end
    end
    assign ent = r_tbl[rd_addr];

    // Next-state logic of the event steps.
    always_comb begin
        n_ahead  = r_ahead;
        n_acnt   = r_acnt;
        n_ghead  = r_ghead;
        n_gcnt   = r_gcnt;
        n_rsp_v  = r_rsp_v;
        n_rsp_id = r_rsp_id;
        n_rdp_v  = r_rdp_v;
        n_rdp_id = r_rdp_id;
        n_disp   = r_disp;
        n_pick   = r_pick;
        n_both   = r_both;
        n_pid    = r_pid;
        tbl_we   = 1'b0;
        tbl_wa   = rd_addr;
        tbl_wd   = ent;
        aq_we    = 1'b0;
        aq_wa    = r_ahead + r_acnt[QP_W-1:0];
        aq_wd    = r_tid;
        gq_we    = 1'b0;
        gq_wa    = r_ghead + r_gcnt[QP_W-1:0];
        gq_wd    = r_tid;
        em[0]    = '0;
        em[1]    = '0;
        em_n     = 2'd0;
        upd      = ent;
        full_q   = 1'b0;
        sp_free  = !r_rsp_v;
        dp_free  = !r_rdp_v;

        if (i_cmd.exec) begin
            n_disp = 1'b0;
            n_pick = 1'b0;
            case (r_op)
                OP_SUBMIT: begin
                    full_q = (r_kind == KIND_AUDIO) ? (r_acnt == CNT_W'(QUEUE_DEPTH))
                                                    : (r_gcnt == CNT_W'(QUEUE_DEPTH));
                    if (full_q) begin
                        em[0] = '{action: ACT_ERROR, id: r_tid, rdp: 1'b0};
                        em_n  = 2'd1;
                    end else begin
                        tbl_we = 1'b1;
                        tbl_wa = r_tid;
                        tbl_wd = '{kind: r_kind, nrsp: r_nrsp, nrdp: r_nrdp, swap: r_swap,
                                   has_fb: r_hasfb, yielded: 1'b0, yld: 1'b0,
                                   sp: r_nrsp, dp: r_nrdp};
                        if (r_kind == KIND_AUDIO) begin
                            aq_we  = 1'b1;
                            n_acnt = r_acnt + 1'b1;
                        end else begin
                            gq_we  = 1'b1;
                            n_gcnt = r_gcnt + 1'b1;
                        end
                    end
                end
                OP_NOTIFY: begin
                    if ((r_acnt != '0) && r_rsp_v) begin
                        if ((ent.kind != KIND_AUDIO) && !ent.yld) begin
                            upd.yld = 1'b1;
                            tbl_we  = 1'b1;
                            tbl_wd  = upd;
                            em[0]   = '{action: ACT_YIELD, id: r_rsp_id, rdp: 1'b0};
                            em_n    = 2'd1;
                        end
                    end else begin
                        n_disp = 1'b1;
                    end
                end
                OP_RSP_DONE: begin
                    if (!r_rsp_v) begin
                        em[0] = '{action: ACT_ERROR, id: '0, rdp: 1'b0};
                        em_n  = 2'd1;
                    end else begin
                        n_rsp_v = 1'b0;
                        n_disp  = 1'b1;
                        tbl_we  = 1'b1;
                        if (ent.yld && r_ryld) begin
                            upd.yielded = 1'b1;
                            if (r_gcnt == CNT_W'(QUEUE_DEPTH)) begin
                                em[0] = '{action: ACT_ERROR, id: r_rsp_id, rdp: 1'b0};
                                em_n  = 2'd1;
                            end else begin
                                n_ghead = r_ghead - 1'b1;
                                gq_we   = 1'b1;
                                gq_wa   = n_ghead;
                                gq_wd   = r_rsp_id;
                                n_gcnt  = r_gcnt + 1'b1;
                            end
                        end else begin
                            upd.sp = 1'b0;
                            if (!upd.sp && !upd.dp) begin
                                em[0] = '{action: ACT_DONE, id: r_rsp_id, rdp: 1'b0};
                                em[1] = '{action: ACT_SWAP, id: r_rsp_id, rdp: 1'b0};
                                em_n  = upd.swap ? 2'd2 : 2'd1;
                            end
                        end
                        tbl_wd = upd;
                    end
                end
                default: begin
                    if (!r_rdp_v) begin
                        em[0] = '{action: ACT_ERROR, id: '0, rdp: 1'b0};
                        em_n  = 2'd1;
                    end else begin
                        n_rdp_v = 1'b0;
                        n_disp  = 1'b1;
                        upd.dp  = 1'b0;
                        tbl_we  = 1'b1;
                        tbl_wd  = upd;
                        if (!upd.sp && !upd.dp) begin
                            em[0] = '{action: ACT_DONE, id: r_rdp_id, rdp: 1'b0};
                            em[1] = '{action: ACT_SWAP, id: r_rdp_id, rdp: 1'b0};
                            em_n  = upd.swap ? 2'd2 : 2'd1;
                        end
                    end
                end
            endcase
        end

        // Dispatch selection: audio first, then the head of the graphics deque.
        if (i_cmd.dsel && r_disp) begin
            if (sp_free && (r_acnt != '0)) begin
                n_pick  = 1'b1;
                n_both  = 1'b0;
                n_pid   = r_afifo[r_ahead];
                n_ahead = r_ahead + 1'b1;
                n_acnt  = r_acnt - 1'b1;
            end else if (r_gcnt != '0) begin
                if (ent.yielded || !ent.nrdp) begin
                    if (sp_free) begin
                        n_pick = 1'b1;
                        n_both = 1'b0;
                    end
                end else if (sp_free && dp_free && (!ent.has_fb || r_fbok)) begin
                    n_pick = 1'b1;
                    n_both = 1'b1;
                end
                if (n_pick) begin
                    n_pid   = hid;
                    n_ghead = r_ghead + 1'b1;
                    n_gcnt  = r_gcnt - 1'b1;
                end
            end
        end

        // Dispatch apply: a null task completes, any other starts on the RSP.
        if (i_cmd.dapp && r_pick) begin
            tbl_we = 1'b1;
            if (ent.kind == KIND_NULL) begin
                if (ent.nrsp) begin
                    upd.sp  = 1'b0;
                    n_rsp_v = 1'b0;
                end
                if (ent.nrdp) begin
                    upd.dp  = 1'b0;
                    n_rdp_v = 1'b0;
                end
                if (!upd.sp && !upd.dp) begin
                    em[0] = '{action: ACT_DONE, id: r_pid, rdp: 1'b0};
                    em[1] = '{action: ACT_SWAP, id: r_pid, rdp: 1'b0};
                    em_n  = upd.swap ? 2'd2 : 2'd1;
                end
            end else begin
                upd.yld     = 1'b0;
                upd.yielded = 1'b0;
                n_rsp_v     = 1'b1;
                n_rsp_id    = r_pid;
                if (r_both && !r_rdp_v) begin
                    n_rdp_v  = 1'b1;
                    n_rdp_id = r_pid;
                end
                em[0] = '{action: ACT_START, id: r_pid, rdp: r_both && !r_rdp_v};
                em_n  = 2'd1;
            end
            tbl_wd = upd;
        end
    end

    assign o_stat.emit_last = (r_rcnt == 3'd0) || ({1'b0, r_eidx} == r_rcnt - 3'd1);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ahead  <= '0;
            r_acnt   <= '0;
            r_ghead  <= '0;
            r_gcnt   <= '0;
            r_rsp_v  <= 1'b0;
            r_rdp_v  <= 1'b0;
            r_rsp_id <= '0;
            r_rdp_id <= '0;
            r_disp   <= 1'b0;
            r_pick   <= 1'b0;
            r_both   <= 1'b0;
            r_pid    <= '0;
            r_rcnt   <= '0;
            r_eidx   <= '0;
            o_valid  <= 1'b0;
        end else begin
            r_ahead  <= n_ahead;
            r_acnt   <= n_acnt;
            r_ghead  <= n_ghead;
            r_gcnt   <= n_gcnt;
            r_rsp_v  <= n_rsp_v;
            r_rdp_v  <= n_rdp_v;
            r_rsp_id <= n_rsp_id;
            r_rdp_id <= n_rdp_id;
            r_disp   <= n_disp;
            r_pick   <= n_pick;
            r_both   <= n_both;
            r_pid    <= n_pid;
            o_valid  <= 1'b0;
            if (i_cmd.latch) begin
                r_rcnt <= '0;
                r_eidx <= '0;
            end else if (i_cmd.emit) begin
                if (r_rcnt != 3'd0) begin
                    o_valid <= 1'b1;
                    r_eidx  <= r_eidx + 1'b1;
                end
            end else begin
                r_rcnt <= r_rcnt + {1'b0, em_n};
            end
        end
    end

    // Payload registers: latched event, result buffer, stores and outputs.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op    <= i_operation;
            r_tid   <= i_task_id;
            r_kind  <= i_task_kind;
            r_nrsp  <= i_needs_rsp;
            r_nrdp  <= i_needs_rdp;
            r_swap  <= i_swap_buffer;
            r_hasfb <= i_has_framebuffer;
            r_fbok  <= i_framebuffer_ok;
            r_ryld  <= i_rsp_yielded;
        end
        if (em_n != 2'd0) begin
            r_rb[r_rcnt[1:0]] <= em[0];
        end
        if (em_n == 2'd2) begin
            r_rb[r_rcnt[1:0] + 2'd1] <= em[1];
        end
        if (tbl_we) begin
            r_tbl[tbl_wa] <= tbl_wd;
        end
        if (aq_we) begin
            r_afifo[aq_wa] <= aq_wd;
        end
        if (gq_we) begin
            r_gdq[gq_wa] <= gq_wd;
        end
        if (i_cmd.emit) begin
            o_action      <= r_rb[r_eidx].action;
            o_task_id_res <= r_rb[r_eidx].id;
            o_with_rdp    <= r_rb[r_eidx].rdp;
            o_last        <= o_stat.emit_last;
        end
    end

endmodule

// File: rtl/rcp_task_dispatcher_core.sv
// Task dispatcher top level: an event is latched, then walks through execute, select and apply,
// then emits its results; busy is high from the execute step until emitting ends.
// The step sequence (execute, select, apply, emit) runs over one table port.
// Results appear one per cycle once emitting begins; the receiver cannot stall.
// Synchronous active-low reset empties both queues and marks both units idle.
module rcp_task_dispatcher_core import rtd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_operation,
    input  logic [3:0] i_task_id,
    input  logic [1:0] i_task_kind,
    input  logic       i_needs_rsp,
    input  logic       i_needs_rdp,
    input  logic       i_swap_buffer,
    input  logic       i_has_framebuffer,
    input  logic       i_framebuffer_ok,
    input  logic       i_rsp_yielded,
    output logic       o_valid,
    output logic [2:0] o_action,
    output logic [3:0] o_task_id_res,
    output logic       o_with_rdp,
    output logic       o_last
);

    t_cmd  cmd;
    t_stat stat;

    // Controller.
    rtd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Datapath.
    rtd_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_operation       (i_operation),
        .i_task_id         (i_task_id),
        .i_task_kind       (i_task_kind),
        .i_needs_rsp       (i_needs_rsp),
        .i_needs_rdp       (i_needs_rdp),
        .i_swap_buffer     (i_swap_buffer),
        .i_has_framebuffer (i_has_framebuffer),
        .i_framebuffer_ok  (i_framebuffer_ok),
        .i_rsp_yielded     (i_rsp_yielded),
        .o_valid           (o_valid),
        .o_action          (o_action),
        .o_task_id_res     (o_task_id_res),
        .o_with_rdp        (o_with_rdp),
        .o_last            (o_last)
    );

endmodule

// File: rtl/rtd_chk.sv
// Port-level checker of the task dispatcher, bound to the top level.
// Depends on assert_macros.svh and rtd_pkg for the action codes.
`include "assert_macros.svh"

module rtd_chk import rtd_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_valid,
    input logic [2:0] o_action,
    input logic       o_last
);

    // An accepted event keeps the block busy in the following cycle.
    `AST_NEXT(a_busy_after_start, start && !busy, busy)
    // Results of one event come in consecutive cycles until the last one.
    `AST_NEXT(a_burst_runs, o_valid && !o_last, o_valid)
    // Nothing follows the last result directly.
    `AST_NEXT(a_gap_after_last, o_valid && o_last, !o_valid)
    // Only defined action codes are shown.
    `AST_SAME(a_action_code, o_valid, o_action <= ACT_ERROR)

endmodule

bind rcp_task_dispatcher_core rtd_chk u_chk (.*);
